[rtl/core/ugpi_pkg.sv]
// Package with shared types, constants and codes of the grid point index.
`timescale 1ns / 1ps
package ugpi_pkg;

  localparam int PointCapacity = 64;
  localparam int GridSide      = 64;
  localparam int GridHeight    = 64;

  localparam logic [2:0] CfgCornerX = 3'd0;
  localparam logic [2:0] CfgCornerY = 3'd1;
  localparam logic [2:0] CfgCornerZ = 3'd2;
  localparam logic [2:0] CfgSizeX   = 3'd3;
  localparam logic [2:0] CfgSizeY   = 3'd4;
  localparam logic [2:0] CfgSizeZ   = 3'd5;
  localparam logic [2:0] CfgCountX  = 3'd6;
  localparam logic [2:0] CfgCountY  = 3'd7;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncBox    = 2'd1;
  localparam logic [1:0] FuncSphere = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StHit      = 3'd1;
  localparam logic [2:0] StNoHits   = 3'd2;
  localparam logic [2:0] StOutside  = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StInvalid  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_INSERT,
    S_READ,
    S_TEST,
    S_SQ,
    S_EMIT,
    S_DONE,
    S_SINGLE
  } state_e;

  // Start request and result of the shared divider.
  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/ugpi_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by all cell lookups.
`timescale 1ns / 1ps
module ugpi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ugpi_pkg::div_req_t req_i,
  output ugpi_pkg::div_rsp_t rsp_o
);

  logic [16:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [15:0] trial;
  logic [16:0] shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[16]};
    trial   = 16'd0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = 16'd0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[15:0], 1'b0};
      if (shifted >= {2'b00, dvs_q}) begin
        trial    = 16'(shifted - {2'b00, dvs_q});
        quo_d[0] = 1'b1;
      end else begin
        trial = shifted[15:0];
      end
      rem_d = trial;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/core/ugpi_store.sv]
// Point store: ids, positions and packed cells, one write and one read port.
`timescale 1ns / 1ps
module ugpi_store #(
  parameter int Capacity = ugpi_pkg::PointCapacity,
  localparam int Aw = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [15:0]   wid_i,
  input  logic [15:0]   wx_i,
  input  logic [15:0]   wy_i,
  input  logic [15:0]   wz_i,
  input  logic [23:0]   wcell_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [15:0]   rid_o,
  output logic [15:0]   rx_o,
  output logic [15:0]   ry_o,
  output logic [15:0]   rz_o,
  output logic [23:0]   rcell_o
);

  logic [87:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wid_i, wx_i, wy_i, wz_i, wcell_i};
    end
    {rid_o, rx_o, ry_o, rz_o, rcell_o} <= mem_q[raddr_i];
  end

endmodule

[rtl/core/uniform_grid_point_index.sv]
// Top level of the uniform grid point index with its sequencer.
`timescale 1ns / 1ps
// Usage: configure with cfg_valid_i/cfg_ready_o, cfg_index_i and cfg_data_i while idle.
// An item is transferred when start_i is high and busy_o is low. Each result
// appears for one cycle with valid_o high; last_o marks the final one of an item.
// The receiver cannot stall; hits never come out back to back.
// Cell coordinates come from one shared divider producing one quotient bit
// per cycle; a negative offset clamps to cell 0 without a division. An insert
// takes up to three divisions. A query takes up to six divisions and
// then sweeps the store twice per distinct cell key among its hits, plus one
// final sweep: each sweep reads and tests every stored point in turn (a sphere
// test computes its three squared differences one after another through one
// multiplier). A new item can be taken in the cycle that carries the last
// result of the previous one.
// Reset clears the configuration to its defaults and empties the store.
module uniform_grid_point_index #(
  parameter int PointCapacity = ugpi_pkg::PointCapacity,
  parameter int GridSide      = ugpi_pkg::GridSide,
  parameter int GridHeight    = ugpi_pkg::GridHeight,
  localparam int Aw = (PointCapacity > 1) ? $clog2(PointCapacity) : 1,
  localparam int Cw = $clog2(PointCapacity + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        point_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] high_x_i,
  input  logic signed [15:0] high_y_i,
  input  logic signed [15:0] high_z_i,
  input  logic [14:0]        radius_i,
  output logic               valid_o,
  output logic [2:0]         status_o,
  output logic [15:0]        hit_id_o,
  output logic               last_o
);

  // Configuration registers.
  logic signed [15:0] corner_q [3];
  logic [14:0]        size_q [3];
  logic [6:0]         cnt_xy_q [2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q[0] <= '0; corner_q[1] <= '0; corner_q[2] <= '0;
      size_q[0] <= 15'd256; size_q[1] <= 15'd256; size_q[2] <= 15'd256;
      cnt_xy_q[0] <= 7'd64; cnt_xy_q[1] <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ugpi_pkg::CfgCornerX: corner_q[0] <= cfg_data_i;
        ugpi_pkg::CfgCornerY: corner_q[1] <= cfg_data_i;
        ugpi_pkg::CfgCornerZ: corner_q[2] <= cfg_data_i;
        ugpi_pkg::CfgSizeX:   size_q[0] <= cfg_data_i[14:0];
        ugpi_pkg::CfgSizeY:   size_q[1] <= cfg_data_i[14:0];
        ugpi_pkg::CfgSizeZ:   size_q[2] <= cfg_data_i[14:0];
        ugpi_pkg::CfgCountX:  cnt_xy_q[0] <= cfg_data_i[6:0];
        ugpi_pkg::CfgCountY:  cnt_xy_q[1] <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Effective cell counts, as 9-bit values.
  logic [8:0] eff_cnt [3];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (cnt_xy_q[a] == 7'd0) eff_cnt[a] = 9'd1;
      else if ({2'b00, cnt_xy_q[a]} > 9'(GridSide)) eff_cnt[a] = 9'(GridSide);
      else eff_cnt[a] = {2'b00, cnt_xy_q[a]};
    end
    eff_cnt[2] = 9'(GridHeight);
  end

  // Latched item.
  logic [1:0]         func_q;
  logic [15:0]        id_q;
  logic signed [17:0] lo_pt_q [3];
  logic signed [17:0] hi_pt_q [3];
  logic signed [15:0] ctr_q [3];
  logic [29:0]        r2_q;

  // Control state.
  ugpi_pkg::state_e state_q, state_d;
  logic [2:0]  step_q, step_d;       // which of six divisions
  logic        inside_q, inside_d;
  logic [7:0]  cell_q [6];
  logic [7:0]  cell_d [6];
  logic [Cw-1:0] count_q, count_d;
  logic [Aw-1:0] scan_q, scan_d;
  logic          phase_q, phase_d;   // 0 search min key, 1 emit
  logic [23:0]   cur_q, cur_d;       // key being emitted
  logic          cur_v_q, cur_v_d;
  logic [23:0]   min_q, min_d;
  logic          min_v_q, min_v_d;
  logic          pend_q, pend_d;     // hit held back to find the last one
  logic [15:0]   pend_id_q, pend_id_d;
  logic [1:0]    sq_q, sq_d;
  logic [33:0]   acc_q, acc_d;
  logic [2:0]    single_q, single_d;
  logic          out_v_d;
  logic [2:0]    out_st_d;
  logic [15:0]   out_id_d;
  logic          out_last_d;

  // Shared divider.
  ugpi_pkg::div_req_t div_req;
  ugpi_pkg::div_rsp_t div_rsp;

  ugpi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Store.
  logic          st_we;
  logic [15:0]   rd_id, rd_x, rd_y, rd_z;
  logic [23:0]   rd_cell;

  ugpi_store #(.Capacity(PointCapacity)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[Aw-1:0]),
    .wid_i   (id_q),
    .wx_i    (lo_pt_q[0][15:0]),
    .wy_i    (lo_pt_q[1][15:0]),
    .wz_i    (lo_pt_q[2][15:0]),
    .wcell_i ({cell_q[0], cell_q[1], cell_q[2]}),
    .raddr_i (scan_q),
    .rid_o   (rd_id),
    .rx_o    (rd_x),
    .ry_o    (rd_y),
    .rz_o    (rd_z),
    .rcell_o (rd_cell)
  );

  // Offset of the current division's operand.
  logic [1:0]         ax;
  logic signed [17:0] opnd;
  logic signed [18:0] off;
  assign ax   = (step_q >= 3'd3) ? 2'(step_q - 3'd3) : step_q[1:0];
  assign opnd = (step_q >= 3'd3) ? hi_pt_q[ax] : lo_pt_q[ax];
  assign off  = 19'(opnd) - 19'(corner_q[ax]);

  // One squared difference per cycle through the shared multiplier.
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [33:0]        sq;
  logic signed [15:0] qsel;
  always_comb begin
    case (sq_q)
      2'd0:    qsel = rd_x;
      2'd1:    qsel = rd_y;
      default: qsel = rd_z;
    endcase
  end
  assign diff = 17'(qsel) - 17'(ctr_q[sq_q]);
  assign prod = diff * diff;
  assign sq   = $unsigned(prod);

  // Cell range and position tests on the word just read.
  logic in_range, box_ok;
  always_comb begin
    in_range = (rd_cell[23:16] >= cell_q[0]) && (rd_cell[23:16] <= cell_q[3]) &&
               (rd_cell[15:8]  >= cell_q[1]) && (rd_cell[15:8]  <= cell_q[4]) &&
               (rd_cell[7:0]   >= cell_q[2]) && (rd_cell[7:0]   <= cell_q[5]);
    box_ok = ($signed(rd_x) >= lo_pt_q[0]) && ($signed(rd_x) <= hi_pt_q[0]) &&
             ($signed(rd_y) >= lo_pt_q[1]) && ($signed(rd_y) <= hi_pt_q[1]) &&
             ($signed(rd_z) >= lo_pt_q[2]) && ($signed(rd_z) <= hi_pt_q[2]);
  end

  logic sph_ok;
  assign sph_ok = (acc_q + sq) < {4'd0, r2_q};

  logic [Cw-1:0] last_idx;
  assign last_idx = count_q - Cw'(1);

  always_comb begin
    logic hit;
    logic last_read;
    logic [16:0] qv;
    logic [7:0]  cidx;
    hit = 1'b0;
    last_read = 1'b0;
    qv = div_rsp.quotient;
    cidx = 8'd0;
    state_d   = state_q;
    step_d    = step_q;
    inside_d  = inside_q;
    cell_d    = cell_q;
    count_d   = count_q;
    scan_d    = scan_q;
    phase_d   = phase_q;
    cur_d     = cur_q;
    cur_v_d   = cur_v_q;
    min_d     = min_q;
    min_v_d   = min_v_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    single_d  = single_q;
    out_v_d   = 1'b0;
    out_st_d  = ugpi_pkg::StHit;
    out_id_d  = 16'd0;
    out_last_d = 1'b0;
    st_we     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = off[16:0];
    div_req.divisor  = (size_q[ax] == 15'd0) ? 15'd1 : size_q[ax];
    case (state_q)
      ugpi_pkg::S_IDLE: begin
        if (start_i) begin
          step_d   = 3'd0;
          inside_d = 1'b1;
          if (func_i == ugpi_pkg::FuncInsert) begin
            state_d = ugpi_pkg::S_DIV_START;
          end else if (func_i == ugpi_pkg::FuncBox) begin
            if ((pos_x_i < high_x_i) && (pos_y_i < high_y_i) && (pos_z_i < high_z_i))
              state_d = ugpi_pkg::S_DIV_START;
            else begin
              state_d  = ugpi_pkg::S_SINGLE;
              single_d = ugpi_pkg::StInvalid;
            end
          end else if (func_i == ugpi_pkg::FuncSphere) begin
            if (radius_i != 15'd0) state_d = ugpi_pkg::S_DIV_START;
            else begin
              state_d  = ugpi_pkg::S_SINGLE;
              single_d = ugpi_pkg::StInvalid;
            end
          end else begin
            state_d  = ugpi_pkg::S_SINGLE;
            single_d = ugpi_pkg::StInvalid;
          end
        end
      end
      ugpi_pkg::S_DIV_START: begin
        // Negative offsets clamp to cell 0 without a division.
        if (off < 0) begin
          inside_d = 1'b0;
          cell_d[step_q] = 8'd0;
          state_d = ugpi_pkg::S_DIV_WAIT;
          step_d  = step_q;
        end else begin
          div_req.start = 1'b1;
          state_d = ugpi_pkg::S_DIV_WAIT;
        end
      end
      ugpi_pkg::S_DIV_WAIT: begin
        if (div_rsp.done || (off < 0)) begin
          if (off >= 0) begin
            if (qv >= 17'(eff_cnt[ax])) begin
              inside_d = 1'b0;
              cidx = 8'(eff_cnt[ax] - 9'd1);
            end else begin
              cidx = qv[7:0];
            end
            cell_d[step_q] = cidx;
          end
          if ((func_q == ugpi_pkg::FuncInsert && step_q == 3'd2) || step_q == 3'd5) begin
            if (func_q == ugpi_pkg::FuncInsert) state_d = ugpi_pkg::S_INSERT;
            else begin
              state_d = ugpi_pkg::S_READ;
              scan_d  = '0;
              phase_d = 1'b0;
              cur_v_d = 1'b0;
              min_v_d = 1'b0;
              pend_d  = 1'b0;
            end
          end else begin
            step_d  = step_q + 3'd1;
            state_d = ugpi_pkg::S_DIV_START;
          end
        end
      end
      ugpi_pkg::S_INSERT: begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        state_d    = ugpi_pkg::S_IDLE;
        if (!inside_q) out_st_d = ugpi_pkg::StOutside;
        else if (count_q >= Cw'(PointCapacity)) out_st_d = ugpi_pkg::StFull;
        else begin
          out_st_d = ugpi_pkg::StInserted;
          st_we    = 1'b1;
          count_d  = count_q + Cw'(1);
        end
      end
      ugpi_pkg::S_READ: begin
        // Read data for scan_q is valid next cycle.
        if (count_q == '0) state_d = ugpi_pkg::S_DONE;
        else begin
          state_d = ugpi_pkg::S_TEST;
          sq_d    = 2'd0;
          acc_d   = '0;
        end
      end
      ugpi_pkg::S_TEST, ugpi_pkg::S_SQ: begin
        if (state_q == ugpi_pkg::S_SQ || func_q == ugpi_pkg::FuncBox) begin
          if (func_q == ugpi_pkg::FuncBox) hit = in_range && box_ok;
          else if (sq_q == 2'd2) hit = in_range && sph_ok;
          else hit = 1'b0;
        end
        if (func_q == ugpi_pkg::FuncSphere && sq_q != 2'd2) begin
          state_d = ugpi_pkg::S_SQ;
          acc_d   = acc_q + sq;
          sq_d    = sq_q + 2'd1;
        end else begin
          last_read = (Cw'(scan_q) == last_idx);
          if (hit) begin
            if (!phase_q) begin
              // Smallest key above the one already sent.
              if ((!cur_v_q || rd_cell > cur_q) && (!min_v_q || rd_cell < min_q)) begin
                min_d   = rd_cell;
                min_v_d = 1'b1;
              end
            end else if (rd_cell == cur_q) begin
              if (pend_q) begin
                out_v_d  = 1'b1;
                out_id_d = pend_id_q;
              end
              pend_d    = 1'b1;
              pend_id_d = rd_id;
            end
          end
          if (last_read) begin
            scan_d = '0;
            if (!phase_q) begin
              if (min_v_d) begin
                phase_d = 1'b1;
                cur_d   = min_d;
                cur_v_d = 1'b1;
                min_v_d = 1'b0;
                state_d = ugpi_pkg::S_READ;
              end else begin
                state_d = ugpi_pkg::S_DONE;
              end
            end else begin
              phase_d = 1'b0;
              state_d = ugpi_pkg::S_READ;
            end
          end else begin
            scan_d  = scan_q + Aw'(1);
            state_d = ugpi_pkg::S_READ;
          end
        end
      end
      ugpi_pkg::S_DONE: begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        state_d    = ugpi_pkg::S_IDLE;
        if (pend_q) out_id_d = pend_id_q;
        else out_st_d = ugpi_pkg::StNoHits;
        pend_d = 1'b0;
      end
      ugpi_pkg::S_SINGLE: begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        out_st_d   = single_q;
        state_d    = ugpi_pkg::S_IDLE;
      end
      default: state_d = ugpi_pkg::S_IDLE;
    endcase
  end

  // Query bounds latched at start, widened by the radius for spheres.
  always_ff @(posedge clk_i) begin
    if (state_q == ugpi_pkg::S_IDLE && start_i) begin
      func_q <= func_i;
      id_q   <= point_id_i;
      ctr_q[0] <= pos_x_i; ctr_q[1] <= pos_y_i; ctr_q[2] <= pos_z_i;
      r2_q   <= 30'(radius_i * radius_i);
      if (func_i == ugpi_pkg::FuncSphere) begin
        lo_pt_q[0] <= 18'(pos_x_i) - 18'(radius_i);
        lo_pt_q[1] <= 18'(pos_y_i) - 18'(radius_i);
        lo_pt_q[2] <= 18'(pos_z_i) - 18'(radius_i);
        hi_pt_q[0] <= 18'(pos_x_i) + 18'(radius_i);
        hi_pt_q[1] <= 18'(pos_y_i) + 18'(radius_i);
        hi_pt_q[2] <= 18'(pos_z_i) + 18'(radius_i);
      end else begin
        lo_pt_q[0] <= 18'(pos_x_i); lo_pt_q[1] <= 18'(pos_y_i);
        lo_pt_q[2] <= 18'(pos_z_i);
        hi_pt_q[0] <= 18'(high_x_i); hi_pt_q[1] <= 18'(high_y_i);
        hi_pt_q[2] <= 18'(high_z_i);
      end
    end
    cell_q    <= cell_d;
    cur_q     <= cur_d;
    min_q     <= min_d;
    pend_id_q <= pend_id_d;
    acc_q     <= acc_d;
    single_q  <= single_d;
    status_o  <= out_st_d;
    hit_id_o  <= out_id_d;
    last_o    <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ugpi_pkg::S_IDLE;
      step_q   <= '0;
      inside_q <= 1'b0;
      count_q  <= '0;
      scan_q   <= '0;
      phase_q  <= 1'b0;
      cur_v_q  <= 1'b0;
      min_v_q  <= 1'b0;
      pend_q   <= 1'b0;
      sq_q     <= '0;
      valid_o  <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      inside_q <= inside_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      phase_q  <= phase_d;
      cur_v_q  <= cur_v_d;
      min_v_q  <= min_v_d;
      pend_q   <= pend_d;
      sq_q     <= sq_d;
      valid_o  <= out_v_d;
    end
  end

  assign busy_o = (state_q != ugpi_pkg::S_IDLE);

`ifndef NO_ASSERTIONS
  // The store never grows beyond its capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(PointCapacity))
    else $error("store count above capacity");

  // A result flagged last ends the item, so the block is then idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> state_q == ugpi_pkg::S_IDLE)
    else $error("last result while still working");

  // The divider reports done only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ugpi_pkg::S_DIV_WAIT)
    else $error("divider result outside wait state");
`endif

endmodule

[bench/uniform_grid_point_index_test.sv]
// Self-checking testbench of the grid point index: inserts, box and sphere queries.
`timescale 1ns / 1ps
module uniform_grid_point_index_test;

  typedef struct {
    logic [1:0]         func;
    logic [15:0]        id;
    logic signed [15:0] px, py, pz, hx, hy, hz;
    logic [14:0]        rad;
  } grid_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] hit_id;
    logic        last;
  } grid_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = ugpi_pkg::CfgCornerX;
  logic [15:0]        cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         func_i = ugpi_pkg::FuncInsert;
  logic [15:0]        point_id_i = '0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] high_x_i = '0, high_y_i = '0, high_z_i = '0;
  logic [14:0]        radius_i = '0;
  logic               valid_o;
  logic [2:0]         status_o;
  logic [15:0]        hit_id_o;
  logic               last_o;

  uniform_grid_point_index DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the configuration and the point store.
  logic [15:0] grid_cfg [8];
  logic [15:0] pt_id [ugpi_pkg::PointCapacity];
  int          pt_pos [ugpi_pkg::PointCapacity][3];
  int          pt_cell [ugpi_pkg::PointCapacity];
  int          pt_count = 0;

  grid_op_t  pending_ops[$];
  grid_res_t expected_res[$];
  int        mismatches = 0;
  int        gap = 0;
  int        idle_cycles = 0;
  bit        hold_ops = 1'b0;
  bit        acc;

  function automatic void add_op(grid_op_t op);
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic void add_result(grid_res_t res);
    expected_res.insert(expected_res.size(), res);
  endfunction

  function automatic int eff_size(int axis);
    int s;
    s = grid_cfg[3 + axis] & 16'h7FFF;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic int eff_count(int axis);
    int c;
    if (axis == 2) return ugpi_pkg::GridHeight;
    c = grid_cfg[6 + axis] & 16'h7F;
    if (c == 0) c = 1;
    if (c > ugpi_pkg::GridSide) c = ugpi_pkg::GridSide;
    return c;
  endfunction

  function automatic int grid_cell(int p, int axis, output bit in_grid);
    int off, idx;
    off = p - int'($signed(grid_cfg[axis]));
    in_grid = 1'b0;
    if (off < 0) return 0;
    idx = off / eff_size(axis);
    if (idx >= eff_count(axis)) return eff_count(axis) - 1;
    in_grid = 1'b1;
    return idx;
  endfunction

  function automatic void push_single(logic [2:0] st);
    add_result('{st, 16'd0, 1'b1});
  endfunction

  // Works out the results of one operation and updates the store mirror.
  function automatic void predict_grid_op(grid_op_t op);
    int p[3], h[3], lo[3], hi[3], c[3], q[3];
    int hit_key[$], hit_idx[$];
    int key, m, r;
    longint d, d2;
    bit ins, all_in, ok;
    p = '{int'(op.px), int'(op.py), int'(op.pz)};
    h = '{int'(op.hx), int'(op.hy), int'(op.hz)};
    r = op.rad;
    if (op.func == ugpi_pkg::FuncInsert) begin
      all_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
        c[a] = grid_cell(p[a], a, ins);
        all_in &= ins;
      end
      if (!all_in) push_single(ugpi_pkg::StOutside);
      else if (pt_count >= ugpi_pkg::PointCapacity) push_single(ugpi_pkg::StFull);
      else begin
        pt_id[pt_count] = op.id;
        for (int a = 0; a < 3; a++) pt_pos[pt_count][a] = p[a];
        pt_cell[pt_count] = (c[0] << 16) | (c[1] << 8) | c[2];
        pt_count++;
        push_single(ugpi_pkg::StInserted);
      end
      return;
    end
    if (op.func == ugpi_pkg::FuncBox) begin
      for (int a = 0; a < 3; a++)
        if (!(p[a] < h[a])) begin
          push_single(ugpi_pkg::StInvalid);
          return;
        end
      for (int a = 0; a < 3; a++) begin
        lo[a] = grid_cell(p[a], a, ins);
        hi[a] = grid_cell(h[a], a, ins);
      end
    end else if (op.func == ugpi_pkg::FuncSphere) begin
      if (r == 0) begin
        push_single(ugpi_pkg::StInvalid);
        return;
      end
      for (int a = 0; a < 3; a++) begin
        lo[a] = grid_cell(p[a] - r, a, ins);
        hi[a] = grid_cell(p[a] + r, a, ins);
      end
    end else begin
      push_single(ugpi_pkg::StInvalid);
      return;
    end
    for (int t = 0; t < pt_count; t++) begin
      key = pt_cell[t];
      c = '{(key >> 16) & 255, (key >> 8) & 255, key & 255};
      ok = 1'b1;
      for (int a = 0; a < 3; a++)
        if (c[a] < lo[a] || c[a] > hi[a]) ok = 1'b0;
      if (!ok) continue;
      q = pt_pos[t];
      if (op.func == ugpi_pkg::FuncBox) begin
        for (int a = 0; a < 3; a++)
          if (q[a] < p[a] || q[a] > h[a]) ok = 1'b0;
      end else begin
        d2 = 0;
        for (int a = 0; a < 3; a++) begin
          d = longint'(q[a]) - longint'(p[a]);
          d2 += d * d;
        end
        ok = d2 < longint'(r) * longint'(r);
      end
      if (ok) begin
        // Stable placement by cell key keeps insertion order within a cell.
        m = hit_key.size();
        while (m > 0 && hit_key[m - 1] > key) m--;
        hit_key.insert(m, key);
        hit_idx.insert(m, t);
      end
    end
    if (hit_idx.size() == 0) push_single(ugpi_pkg::StNoHits);
    foreach (hit_idx[i])
      add_result('{ugpi_pkg::StHit, pt_id[hit_idx[i]], i == hit_idx.size() - 1});
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    acc = start_i && !busy_o;
    if (acc) begin
      predict_grid_op(pending_ops.pop_front());
      gap = pick_gap();
    end else if (!start_i && gap > 0) begin
      gap--;
    end
    if (start_i && !acc) begin
      // Hold the item until it is taken.
    end else if (gap == 0 && !(hold_ops && expected_res.size() > 0) &&
                 pending_ops.size() > 0 && rst_ni) begin
      start_i    <= 1'b1;
      func_i     <= pending_ops[0].func;
      point_id_i <= pending_ops[0].id;
      pos_x_i    <= pending_ops[0].px;
      pos_y_i    <= pending_ops[0].py;
      pos_z_i    <= pending_ops[0].pz;
      high_x_i   <= pending_ops[0].hx;
      high_y_i   <= pending_ops[0].hy;
      high_z_i   <= pending_ops[0].hz;
      radius_i   <= pending_ops[0].rad;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    if (valid_o) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d id %0d last %0d",
                   status_o, hit_id_o, last_o);
      end else begin
        if (status_o !== expected_res[0].status || hit_id_o !== expected_res[0].hit_id ||
            last_o !== expected_res[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d id %0d last %0d, got %0d %0d %0d",
                     expected_res[0].status, expected_res[0].hit_id, expected_res[0].last,
                     status_o, hit_id_o, last_o);
        end
        void'(expected_res.pop_front());
      end
    end
    if (valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 50000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    grid_cfg[idx] = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_ops.size() > 0 || expected_res.size() > 0 || start_i || busy_o)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Coordinate mostly inside the current grid, sometimes anywhere.
  function automatic int rand_coord(int axis);
    int span;
    if ($urandom_range(0, 4) == 0) return int'($signed(16'($urandom)));
    span = eff_size(axis) * eff_count(axis);
    return clip16(int'($signed(grid_cfg[axis])) - span / 16 +
                  int'($urandom_range(0, span + span / 8)));
  endfunction

  function automatic grid_op_t rand_op();
    grid_op_t op;
    int sel, c;
    sel = $urandom_range(0, 19);
    op.id  = 16'($urandom);
    op.rad = 15'($urandom);
    op.px = 16'(rand_coord(0));
    op.py = 16'(rand_coord(1));
    op.pz = 16'(rand_coord(2));
    op.hx = 16'($urandom);
    op.hy = 16'($urandom);
    op.hz = 16'($urandom);
    if (sel < 8) begin
      op.func = ugpi_pkg::FuncInsert;
    end else if (sel < 13) begin
      op.func = ugpi_pkg::FuncBox;
      if (sel != 12) begin
        c = eff_size(0) * 3;
        op.hx = clip16(op.px + int'($urandom_range(1, c + 1)));
        op.hy = clip16(op.py + int'($urandom_range(1, eff_size(1) * 3 + 1)));
        op.hz = clip16(op.pz + int'($urandom_range(1, eff_size(2) * 3 + 1)));
      end
    end else if (sel < 19) begin
      op.func = ugpi_pkg::FuncSphere;
      if (sel != 18) op.rad = 15'($urandom_range(1, eff_size(0) * 2 + 1));
    end else begin
      op.func = ugpi_pkg::FuncUnused;
    end
    return op;
  endfunction

  task automatic run_random(int count);
    repeat (count) add_op(rand_op());
    wait_idle();
  endtask

  initial begin
    grid_cfg = '{16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256, 16'd64, 16'd64};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset configuration: a 64 x 64 x 64 grid of cells of size 256.
    add_op('{ugpi_pkg::FuncInsert, 16'h0000, 0, 0, 0, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncInsert, 16'hFFFF, 16383, 16383, 16383, 0, 0, 0, 15'h7FFF});
    add_op('{ugpi_pkg::FuncInsert, 16'h1234, 16384, 100, 100, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncInsert, 16'h4321, 100, -1, 100, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncInsert, 16'h5555, 32767, 32767, -32768, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncInsert, 16'hAAAA, 300, 300, 300, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncInsert, 16'h00FF, 310, 300, 300, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncBox, 16'h0, -32768, -32768, -32768, 32767, 32767, 32767,
             15'd0});
    add_op('{ugpi_pkg::FuncBox, 16'h0, 0, 0, 0, 0, 5, 5, 15'd0});
    add_op('{ugpi_pkg::FuncBox, 16'h0, 1000, 1000, 1000, 2000, 2000, 2000, 15'd0});
    add_op('{ugpi_pkg::FuncBox, 16'h0, 300, 300, 300, 301, 301, 301, 15'd0});
    add_op('{ugpi_pkg::FuncSphere, 16'h0, 300, 300, 300, 0, 0, 0, 15'd0});
    add_op('{ugpi_pkg::FuncSphere, 16'h0, 300, 300, 300, 0, 0, 0, 15'd10});
    add_op('{ugpi_pkg::FuncSphere, 16'h0, 300, 300, 300, 0, 0, 0, 15'd11});
    add_op('{ugpi_pkg::FuncSphere, 16'h0, -32768, -32768, -32768, 0, 0, 0, 15'h7FFF});
    add_op('{ugpi_pkg::FuncSphere, 16'h0, 32767, 32767, 32767, 0, 0, 0, 15'h7FFF});
    add_op('{ugpi_pkg::FuncUnused, 16'hFFFF, -1, -1, -1, -1, -1, -1, 15'h7FFF});
    // Sender holds each item until every result of the previous ones is in.
    hold_ops = 1'b1;
    wait_idle();
    hold_ops = 1'b0;
    wait_idle();

    run_random(60);

    write_reg(ugpi_pkg::CfgCornerX, -16'sd4096);
    write_reg(ugpi_pkg::CfgCornerY, -16'sd4096);
    write_reg(ugpi_pkg::CfgCornerZ, -16'sd4096);
    write_reg(ugpi_pkg::CfgSizeX, 16'd200);
    write_reg(ugpi_pkg::CfgSizeY, 16'd300);
    write_reg(ugpi_pkg::CfgSizeZ, 16'd128);
    write_reg(ugpi_pkg::CfgCountX, 16'd40);
    write_reg(ugpi_pkg::CfgCountY, 16'd64);
    run_random(60);

    // Degenerate values: zero size and zero count act as one, oversize count is capped.
    write_reg(ugpi_pkg::CfgCornerX, 16'h8000);
    write_reg(ugpi_pkg::CfgCornerY, 16'h8000);
    write_reg(ugpi_pkg::CfgCornerZ, 16'h8000);
    write_reg(ugpi_pkg::CfgSizeX, 16'h7FFF);
    write_reg(ugpi_pkg::CfgSizeY, 16'd0);
    write_reg(ugpi_pkg::CfgSizeZ, 16'd1);
    write_reg(ugpi_pkg::CfgCountX, 16'd0);
    write_reg(ugpi_pkg::CfgCountY, 16'd127);
    run_random(60);

    write_reg(ugpi_pkg::CfgCornerX, 16'h7FFF);
    write_reg(ugpi_pkg::CfgCornerY, 16'h7FFF);
    write_reg(ugpi_pkg::CfgCornerZ, 16'h7FFF);
    write_reg(ugpi_pkg::CfgSizeX, 16'd1);
    write_reg(ugpi_pkg::CfgSizeY, 16'h7FFF);
    write_reg(ugpi_pkg::CfgSizeZ, 16'h7FFF);
    write_reg(ugpi_pkg::CfgCountX, 16'd1);
    write_reg(ugpi_pkg::CfgCountY, 16'd1);
    run_random(60);

    write_reg(ugpi_pkg::CfgCornerX, -16'sd10000);
    write_reg(ugpi_pkg::CfgCornerY, -16'sd256);
    write_reg(ugpi_pkg::CfgCornerZ, 16'sd100);
    write_reg(ugpi_pkg::CfgSizeX, 16'd512);
    write_reg(ugpi_pkg::CfgSizeY, 16'd64);
    write_reg(ugpi_pkg::CfgSizeZ, 16'd700);
    write_reg(ugpi_pkg::CfgCountX, 16'd20);
    write_reg(ugpi_pkg::CfgCountY, 16'd64);
    run_random(60);

    write_reg(ugpi_pkg::CfgCornerX, 16'd0);
    write_reg(ugpi_pkg::CfgCornerY, 16'd0);
    write_reg(ugpi_pkg::CfgCornerZ, 16'd0);
    write_reg(ugpi_pkg::CfgSizeX, 16'd256);
    write_reg(ugpi_pkg::CfgSizeY, 16'd256);
    write_reg(ugpi_pkg::CfgSizeZ, 16'd256);
    write_reg(ugpi_pkg::CfgCountX, 16'd64);
    write_reg(ugpi_pkg::CfgCountY, 16'd64);
    run_random(60);

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
